// ----- design/ble_pkg.sv -----
package ble_pkg;

   // Fixed sizes of the list and its fields.
   localparam int DATA_WIDTH  = 32;
   localparam int MAX_ENTRIES = 16;
   localparam int ADDR_WIDTH  = $clog2(MAX_ENTRIES);
   localparam int CNT_WIDTH   = 5;
   localparam int OP_WIDTH    = 4;
   localparam int STAT_WIDTH  = 2;

   localparam logic [CNT_WIDTH-1:0] CNT_MAX   = CNT_WIDTH'(MAX_ENTRIES);
   localparam logic [CNT_WIDTH-1:0] CAP_RESET = CNT_WIDTH'(10);

   typedef logic [DATA_WIDTH-1:0] word_type;
   typedef logic [ADDR_WIDTH-1:0] addr_type;
   typedef logic [CNT_WIDTH-1:0]  cnt_type;

   // Operation codes carried by a request.
   typedef enum logic [OP_WIDTH-1:0] {
      OP_CLEAR      = 4'd0,
      OP_INSERT     = 4'd1,
      OP_APPEND     = 4'd2,
      OP_PUSH_FRONT = 4'd3,
      OP_SORTED     = 4'd4,
      OP_POP        = 4'd5,
      OP_POP_BACK   = 4'd6,
      OP_POP_FIRST  = 4'd7,
      OP_REMOVE     = 4'd8,
      OP_FIND       = 4'd9,
      OP_READ       = 4'd10,
      OP_WRITE      = 4'd11
   } op_type;

   // Status codes returned with each result.
   typedef enum logic [STAT_WIDTH-1:0] {
      STAT_OK     = 2'd0,
      STAT_FULL   = 2'd1,
      STAT_EMPTY  = 2'd2,
      STAT_BADPOS = 2'd3
   } status_type;

   typedef struct packed {
      logic [OP_WIDTH-1:0]  opcode;
      cnt_type              position;
      word_type             value;
   } req_type;

   typedef struct packed {
      logic [STAT_WIDTH-1:0] status;
      word_type              result_value;
      cnt_type               found_position;
      logic                  found;
      cnt_type               entry_count;
   } rsp_type;

   // Outcome of the shared compare unit.
   typedef struct packed {
      logic eq;
      logic gt;
   } cmp_type;

endpackage

// ----- design/ble_mem.sv -----
module ble_mem (
   input  logic             clock,
   input  logic             we,
   input  ble_pkg::addr_type waddr,
   input  ble_pkg::word_type wdata,
   input  ble_pkg::addr_type raddr,
   output ble_pkg::word_type rdata
);

   ble_pkg::word_type entries_ff [ble_pkg::MAX_ENTRIES];
   ble_pkg::word_type rdata_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         entries_ff[waddr] <= wdata;
      end
      rdata_ff <= entries_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- design/ble_cmp.sv -----
module ble_cmp (
   input  ble_pkg::word_type a,
   input  ble_pkg::word_type b,
   output ble_pkg::cmp_type  res
);

   // Equality and signed greater-than, shared by find, remove and sorted insert.
   always_comb begin
      res.eq = (a == b);
      res.gt = ($signed(a) > $signed(b));
   end

endmodule

// ----- design/bounded_array_list_engine.sv -----
// Bounded ordered list of up to 16 signed 32-bit words held in a small entry
// memory with one write port and one registered read port. A request is taken
// when start is high and busy is low; busy then stays high until the result is
// produced. The result appears on rsp_data for exactly one cycle with rsp_valid
// high and must be captured then, since the receiver cannot stall it; busy is
// already low in that cycle, so the next request may be issued alongside it.
// Clear, write, unused opcodes and any request rejected with a full, empty or
// bad-position status finish in the decode state, and a read fetches one
// entry. Inserts move entries up one at a time, and pops fetch the entry and
// then move the rest down. Find and remove compare entries one by one, and a
// successful remove then moves the rest down. A sorted insert scans and then
// shifts, and the scan and the shift together cover every entry. The result
// appears in the same cycle that busy drops. The walks go one memory access
// at a time, set by the single read port of the entry memory; the longest
// requests are a sorted insert into 15 entries and a failed search of 16. The
// capacity register is written through the csr channel, which is always ready.
module bounded_array_list_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ble_pkg::req_type  req_data,
   output logic              rsp_valid,
   output ble_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  ble_pkg::cnt_type  csr_data
);

   typedef enum logic [9:0] {
      ST_IDLE      = 10'b0000000001,
      ST_DECODE    = 10'b0000000010,
      ST_SCAN_RD   = 10'b0000000100,
      ST_SCAN_CMP  = 10'b0000001000,
      ST_SHUP_RD   = 10'b0000010000,
      ST_SHUP_WR   = 10'b0000100000,
      ST_FETCH     = 10'b0001000000,
      ST_FETCH_CAP = 10'b0010000000,
      ST_SHDN_RD   = 10'b0100000000,
      ST_SHDN_WR   = 10'b1000000000
   } state_type;

   state_type                           state_ff, state_in;
   ble_pkg::cnt_type                    count_ff, count_in;
   ble_pkg::cnt_type                    cap_ff, cap_in;
   logic [ble_pkg::OP_WIDTH-1:0]        op_ff, op_in;
   ble_pkg::cnt_type                    pos_ff, pos_in;
   ble_pkg::word_type                   val_ff, val_in;
   ble_pkg::cnt_type                    idx_ff, idx_in;
   ble_pkg::cnt_type                    tgt_ff, tgt_in;
   logic [ble_pkg::STAT_WIDTH-1:0]      stat_ff, stat_in;
   ble_pkg::word_type                   rv_ff, rv_in;
   ble_pkg::cnt_type                    fpos_ff, fpos_in;
   logic                                found_ff, found_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   ble_pkg::rsp_type                    rsp_ff, rsp_in;

   logic                                finish;
   logic                                mem_we;
   ble_pkg::addr_type                   mem_waddr;
   ble_pkg::word_type                   mem_wdata;
   ble_pkg::addr_type                   mem_raddr;
   ble_pkg::word_type                   mem_rdata;
   ble_pkg::cmp_type                    cmp;

   ble_pkg::cnt_type                    cap_eff;
   ble_pkg::cnt_type                    idx_inc;
   ble_pkg::cnt_type                    idx_dec;
   ble_pkg::cnt_type                    ins_pos;
   ble_pkg::cnt_type                    pop_pos;
   logic                                is_full;
   logic                                is_empty;
   logic                                hit;

   // Entry storage and the shared compare unit.
   ble_mem u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   ble_cmp u_cmp (
      .a   (val_ff),
      .b   (mem_rdata),
      .res (cmp)
   );

   // Capacity clamped into the range one to the number of entries.
   always_comb begin
      priority if (cap_ff == '0) begin
         cap_eff = ble_pkg::cnt_type'(1);
      end else if (cap_ff > ble_pkg::CNT_MAX) begin
         cap_eff = ble_pkg::CNT_MAX;
      end else begin
         cap_eff = cap_ff;
      end
   end

   // Helpers used by the sequencer.
   always_comb begin
      idx_inc  = idx_ff + ble_pkg::cnt_type'(1);
      idx_dec  = idx_ff - ble_pkg::cnt_type'(1);
      is_full  = (count_ff >= cap_eff);
      is_empty = (count_ff == '0);
      hit      = (op_ff == ble_pkg::OP_SORTED) ? !cmp.gt : cmp.eq;

      priority if (op_ff == ble_pkg::OP_INSERT) begin
         ins_pos = pos_ff;
      end else if (op_ff == ble_pkg::OP_APPEND) begin
         ins_pos = count_ff;
      end else begin
         ins_pos = '0;
      end

      priority if (op_ff == ble_pkg::OP_POP_BACK) begin
         pop_pos = count_ff - ble_pkg::cnt_type'(1);
      end else if (op_ff == ble_pkg::OP_POP_FIRST) begin
         pop_pos = '0;
      end else begin
         pop_pos = pos_ff;
      end
   end

   // Sequencer: decodes a request, then walks the entries one memory access
   // at a time to search, shift up or shift down.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      idx_in       = idx_ff;
      tgt_in       = tgt_ff;
      stat_in      = stat_ff;
      rv_in        = rv_ff;
      fpos_in      = fpos_ff;
      found_in     = found_ff;
      finish       = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = idx_ff[ble_pkg::ADDR_WIDTH-1:0];
      mem_wdata    = mem_rdata;
      mem_raddr    = idx_ff[ble_pkg::ADDR_WIDTH-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in    = req_data.opcode;
               pos_in   = req_data.position;
               val_in   = req_data.value;
               stat_in  = ble_pkg::STAT_OK;
               rv_in    = '0;
               fpos_in  = '0;
               found_in = 1'b0;
               state_in = ST_DECODE;
            end
         end

         ST_DECODE: begin
            unique case (op_ff)
               ble_pkg::OP_CLEAR: begin
                  count_in = '0;
                  finish   = 1'b1;
               end
               ble_pkg::OP_INSERT, ble_pkg::OP_APPEND, ble_pkg::OP_PUSH_FRONT: begin
                  priority if (is_full) begin
                     stat_in = ble_pkg::STAT_FULL;
                     finish  = 1'b1;
                  end else if (ins_pos > count_ff) begin
                     stat_in = ble_pkg::STAT_BADPOS;
                     finish  = 1'b1;
                  end else begin
                     tgt_in   = ins_pos;
                     idx_in   = count_ff;
                     state_in = ST_SHUP_RD;
                  end
               end
               ble_pkg::OP_SORTED: begin
                  if (is_full) begin
                     stat_in = ble_pkg::STAT_FULL;
                     finish  = 1'b1;
                  end else begin
                     idx_in   = '0;
                     state_in = ST_SCAN_RD;
                  end
               end
               ble_pkg::OP_POP, ble_pkg::OP_POP_BACK, ble_pkg::OP_POP_FIRST: begin
                  priority if (is_empty) begin
                     stat_in = ble_pkg::STAT_EMPTY;
                     finish  = 1'b1;
                  end else if (pop_pos >= count_ff) begin
                     stat_in = ble_pkg::STAT_BADPOS;
                     finish  = 1'b1;
                  end else begin
                     idx_in   = pop_pos;
                     state_in = ST_FETCH;
                  end
               end
               ble_pkg::OP_REMOVE, ble_pkg::OP_FIND: begin
                  idx_in   = '0;
                  state_in = ST_SCAN_RD;
               end
               ble_pkg::OP_READ, ble_pkg::OP_WRITE: begin
                  priority if (is_empty) begin
                     stat_in = ble_pkg::STAT_EMPTY;
                     finish  = 1'b1;
                  end else if (pos_ff >= count_ff) begin
                     stat_in = ble_pkg::STAT_BADPOS;
                     finish  = 1'b1;
                  end else if (op_ff == ble_pkg::OP_READ) begin
                     idx_in   = pos_ff;
                     state_in = ST_FETCH;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = pos_ff[ble_pkg::ADDR_WIDTH-1:0];
                     mem_wdata = val_ff;
                     finish    = 1'b1;
                  end
               end
               default: begin
                  finish = 1'b1;
               end
            endcase
         end

         // Search: read one entry, compare it in the next cycle.
         ST_SCAN_RD: begin
            if (idx_ff == count_ff) begin
               if (op_ff == ble_pkg::OP_SORTED) begin
                  tgt_in   = count_ff;
                  idx_in   = count_ff;
                  state_in = ST_SHUP_RD;
               end else begin
                  fpos_in = count_ff;
                  finish  = 1'b1;
               end
            end else begin
               state_in = ST_SCAN_CMP;
            end
         end

         ST_SCAN_CMP: begin
            if (hit) begin
               if (op_ff == ble_pkg::OP_SORTED) begin
                  tgt_in   = idx_ff;
                  idx_in   = count_ff;
                  state_in = ST_SHUP_RD;
               end else begin
                  fpos_in  = idx_ff;
                  found_in = 1'b1;
                  if (op_ff == ble_pkg::OP_REMOVE) begin
                     state_in = ST_SHDN_RD;
                  end else begin
                     finish = 1'b1;
                  end
               end
            end else begin
               idx_in   = idx_inc;
               state_in = ST_SCAN_RD;
            end
         end

         // Shift up: move entry idx-1 to idx until the target slot is free.
         ST_SHUP_RD: begin
            if (idx_ff == tgt_ff) begin
               mem_we    = 1'b1;
               mem_waddr = tgt_ff[ble_pkg::ADDR_WIDTH-1:0];
               mem_wdata = val_ff;
               count_in  = count_ff + ble_pkg::cnt_type'(1);
               finish    = 1'b1;
            end else begin
               mem_raddr = idx_dec[ble_pkg::ADDR_WIDTH-1:0];
               state_in  = ST_SHUP_WR;
            end
         end

         ST_SHUP_WR: begin
            mem_we   = 1'b1;
            idx_in   = idx_dec;
            state_in = ST_SHUP_RD;
         end

         // Fetch the entry being popped or read.
         ST_FETCH: begin
            state_in = ST_FETCH_CAP;
         end

         ST_FETCH_CAP: begin
            rv_in = mem_rdata;
            if (op_ff == ble_pkg::OP_READ) begin
               finish = 1'b1;
            end else begin
               state_in = ST_SHDN_RD;
            end
         end

         // Shift down: move entry idx+1 to idx up to the end of the list.
         ST_SHDN_RD: begin
            if (idx_inc >= count_ff) begin
               count_in = count_ff - ble_pkg::cnt_type'(1);
               finish   = 1'b1;
            end else begin
               mem_raddr = idx_inc[ble_pkg::ADDR_WIDTH-1:0];
               state_in  = ST_SHDN_WR;
            end
         end

         ST_SHDN_WR: begin
            mem_we   = 1'b1;
            idx_in   = idx_inc;
            state_in = ST_SHDN_RD;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (finish) begin
         state_in = ST_IDLE;
      end
   end

   // Result register, loaded in the cycle the sequencer finishes.
   always_comb begin
      rsp_valid_in          = finish;
      rsp_in                = rsp_ff;
      if (finish) begin
         rsp_in.status         = stat_in;
         rsp_in.result_value   = rv_in;
         rsp_in.found_position = fpos_in;
         rsp_in.found          = found_in;
         rsp_in.entry_count    = count_in;
      end
   end

   // Capacity register written through the csr channel.
   always_comb begin
      cap_in = cap_ff;
      if (csr_valid && csr_ready) begin
         cap_in = csr_data;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cap_ff       <= ble_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working payload of the request in progress.
   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      pos_ff   <= pos_in;
      val_ff   <= val_in;
      idx_ff   <= idx_in;
      tgt_ff   <= tgt_in;
      stat_ff  <= stat_in;
      rv_ff    <= rv_in;
      fpos_ff  <= fpos_in;
      found_ff <= found_in;
      rsp_ff   <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   // The count never goes beyond the number of entries.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ble_pkg::CNT_MAX)
      else $error("entry count above the list size");

   // An accepted request makes the block busy.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but block not busy");

   // A result is only produced as the sequencer returns to idle.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_IDLE) && $past(state_ff != ST_IDLE))
      else $error("result outside the end of a request");

   // The count only changes together with a result.
   a_count_rsp: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> rsp_valid_ff)
      else $error("entry count changed without a result");

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [ble_pkg::OP_WIDTH-1:0] opc_type;

   // Opcodes the block does not define; they must leave the list untouched.
   localparam opc_type OP_SPARE_LO = 4'd12;
   localparam opc_type OP_SPARE_HI = 4'd15;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASE_COUNT   = 9;
   localparam int PHASE_ITEMS   = 103;
   localparam int QUIET_PHASE   = 4;
   localparam int SETTLE_CYCLES = 40;
   localparam int PRINT_CAP     = 50;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   ble_pkg::req_type req_data;
   logic             rsp_valid;
   ble_pkg::rsp_type rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   ble_pkg::cnt_type csr_data;

   bounded_array_list_engine dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // Shadow copy of the list and of the capacity register.
   ble_pkg::word_type words [ble_pkg::MAX_ENTRIES];
   int                held = 0;
   ble_pkg::cnt_type  cap_setting = ble_pkg::CAP_RESET;

   ble_pkg::req_type  req_backlog [$];
   ble_pkg::rsp_type  awaited_rsp [$];
   bit                req_taken = 1'b0;
   bit                gaps_on = 1'b1;

   int cycles = 0;
   int mismatches = 0;
   int checked = 0;
   int sent = 0;
   int cap_writes = 0;
   int st_seen [4] = '{default: 0};

   always #5 clock = ~clock;

   // Remove the entry at a position, close the gap and hand back the word.
   function automatic ble_pkg::word_type drop_entry(int at);
      ble_pkg::word_type w;
      w = words[at];
      for (int k = at; k + 1 < held; k++) words[k] = words[k + 1];
      held--;
      return w;
   endfunction

   // Apply one request to the shadow list and return the result it must give.
   function automatic ble_pkg::rsp_type list_outcome(ble_pkg::req_type r);
      ble_pkg::rsp_type o;
      int               lim;
      int               at;
      o = '0;
      if (cap_setting == 0) lim = 1;
      else if (cap_setting > ble_pkg::MAX_ENTRIES) lim = ble_pkg::MAX_ENTRIES;
      else lim = int'(cap_setting);
      case (r.opcode)
         ble_pkg::OP_CLEAR: held = 0;
         ble_pkg::OP_INSERT, ble_pkg::OP_APPEND, ble_pkg::OP_PUSH_FRONT,
         ble_pkg::OP_SORTED: begin
            if (r.opcode == ble_pkg::OP_INSERT) at = int'(r.position);
            else if (r.opcode == ble_pkg::OP_APPEND) at = held;
            else if (r.opcode == ble_pkg::OP_PUSH_FRONT) at = 0;
            else begin
               // Sorted insert goes before the first entry that is not smaller.
               at = 0;
               while (at < held && $signed(r.value) > $signed(words[at])) at++;
            end
            if (held >= lim) o.status = ble_pkg::STAT_FULL;
            else if (at > held) o.status = ble_pkg::STAT_BADPOS;
            else begin
               for (int k = held; k > at; k--) words[k] = words[k - 1];
               words[at] = r.value;
               held++;
            end
         end
         ble_pkg::OP_POP, ble_pkg::OP_POP_BACK, ble_pkg::OP_POP_FIRST: begin
            if (r.opcode == ble_pkg::OP_POP) at = int'(r.position);
            else if (r.opcode == ble_pkg::OP_POP_BACK) at = held - 1;
            else at = 0;
            if (held == 0) o.status = ble_pkg::STAT_EMPTY;
            else if (at >= held) o.status = ble_pkg::STAT_BADPOS;
            else o.result_value = drop_entry(at);
         end
         ble_pkg::OP_REMOVE, ble_pkg::OP_FIND: begin
            at = 0;
            while (at < held && words[at] != r.value) at++;
            o.found_position = ble_pkg::cnt_type'(at);
            o.found = (at < held);
            if (o.found && r.opcode == ble_pkg::OP_REMOVE) void'(drop_entry(at));
         end
         ble_pkg::OP_READ, ble_pkg::OP_WRITE: begin
            at = int'(r.position);
            if (held == 0) o.status = ble_pkg::STAT_EMPTY;
            else if (at >= held) o.status = ble_pkg::STAT_BADPOS;
            else if (r.opcode == ble_pkg::OP_READ) o.result_value = words[at];
            else words[at] = r.value;
         end
         default: ;
      endcase
      o.entry_count = ble_pkg::cnt_type'(held);
      return o;
   endfunction

   task automatic flag_mismatch(string field, logic [63:0] got, logic [63:0] want);
      mismatches++;
      if (mismatches <= PRINT_CAP)
         $display("MISMATCH at %0t, result %0d: %s is %0h, expected %0h",
                  $time, checked, field, got, want);
   endtask

   // Result checking, capacity tracking and request acceptance at each rising edge.
   always @(posedge clock) begin
      ble_pkg::rsp_type want;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         if (rsp_valid) begin
            if (awaited_rsp.size() == 0) begin
               flag_mismatch("unexpected result value", rsp_data.result_value, 0);
            end else begin
               want = awaited_rsp[0];
               awaited_rsp.delete(0);
               st_seen[want.status]++;
               if (rsp_data.status !== want.status)
                  flag_mismatch("status", rsp_data.status, want.status);
               if (rsp_data.result_value !== want.result_value)
                  flag_mismatch("result_value", rsp_data.result_value, want.result_value);
               if (rsp_data.found_position !== want.found_position)
                  flag_mismatch("found_position", rsp_data.found_position,
                                want.found_position);
               if (rsp_data.found !== want.found)
                  flag_mismatch("found", rsp_data.found, want.found);
               if (rsp_data.entry_count !== want.entry_count)
                  flag_mismatch("entry_count", rsp_data.entry_count, want.entry_count);
               checked++;
            end
         end
         if (csr_valid && csr_ready) begin
            cap_setting = csr_data;
            cap_writes++;
         end
         req_taken = start && !busy;
         if (req_taken) begin
            awaited_rsp.insert(awaited_rsp.size(), list_outcome(req_data));
            sent++;
         end
      end
   end

   // Request driver: presents the next queued request, with random gaps while gaps_on is set.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         if (req_backlog.size() != 0 && !(gaps_on && $urandom_range(99) < 23)) begin
            req_data <= req_backlog[0];
            req_backlog.delete(0);
            start    <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Verification failed");
         $finish;
      end
   end

   task automatic queue_request(opc_type op, ble_pkg::cnt_type pos,
                                ble_pkg::word_type val);
      ble_pkg::req_type r;
      r.opcode   = op;
      r.position = pos;
      r.value    = val;
      req_backlog.insert(req_backlog.size(), r);
   endtask

   // Random request; a growing phase leans on inserts, a shrinking one on pops.
   function automatic ble_pkg::req_type random_request(bit grow);
      ble_pkg::req_type r;
      int               pick;
      pick = $urandom_range(99);
      if (pick < 2) r.opcode = ble_pkg::OP_CLEAR;
      else if (pick < 4) r.opcode = opc_type'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      else if (pick < (grow ? 50 : 25))
         r.opcode = opc_type'($urandom_range(ble_pkg::OP_INSERT, ble_pkg::OP_SORTED));
      else if (pick < (grow ? 68 : 65))
         r.opcode = opc_type'($urandom_range(ble_pkg::OP_POP, ble_pkg::OP_POP_FIRST));
      else if (pick < 84)
         r.opcode = opc_type'($urandom_range(ble_pkg::OP_REMOVE, ble_pkg::OP_FIND));
      else r.opcode = opc_type'($urandom_range(ble_pkg::OP_READ, ble_pkg::OP_WRITE));

      // Mostly positions that can be legal, sometimes the full field.
      pick = $urandom_range(99);
      if (pick < 70) r.position = ble_pkg::cnt_type'($urandom_range(0, 9));
      else if (pick < 92)
         r.position = ble_pkg::cnt_type'($urandom_range(0, ble_pkg::MAX_ENTRIES));
      else r.position = ble_pkg::cnt_type'($urandom_range(0, 31));

      // A small pool of values makes duplicates, hits and sorted ties common.
      pick = $urandom_range(99);
      if (pick < 60) r.value = ble_pkg::word_type'($urandom_range(0, 8) - 4);
      else if (pick < 72) begin
         case ($urandom_range(3))
            0: r.value = {1'b1, {(ble_pkg::DATA_WIDTH-1){1'b0}}};
            1: r.value = {1'b0, {(ble_pkg::DATA_WIDTH-1){1'b1}}};
            2: r.value = '0;
            default: r.value = '1;
         endcase
      end else r.value = ble_pkg::word_type'($urandom);
      return r;
   endfunction

   // Block until every queued request has been taken and answered.
   task automatic wait_drained();
      while (req_backlog.size() != 0 || start || busy || awaited_rsp.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_capacity(ble_pkg::cnt_type v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      ble_pkg::cnt_type cap_plan [PHASE_COUNT];
      cap_plan = '{5'd16, 5'd0, 5'd31, 5'd3, 5'd1, 5'd17, 5'd12, 5'd16, 5'd2};
      for (int k = 0; k < ble_pkg::MAX_ENTRIES; k++) words[k] = '0;
      clock     = 1'b0;
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_data  = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part at the reset capacity: empty list, extremes, each operation.
      queue_request(ble_pkg::OP_POP_FIRST, 0, 0);
      queue_request(ble_pkg::OP_POP_BACK, 0, 0);
      queue_request(ble_pkg::OP_POP, 0, 0);
      queue_request(ble_pkg::OP_READ, 0, 0);
      queue_request(ble_pkg::OP_WRITE, 0, 32'h5);
      queue_request(ble_pkg::OP_REMOVE, 0, 32'h7);
      queue_request(ble_pkg::OP_FIND, 0, 32'h7);
      queue_request(OP_SPARE_LO, 3, '1);
      queue_request(OP_SPARE_HI, 31, '1);
      queue_request(ble_pkg::OP_APPEND, 0, 32'h7fff_ffff);
      queue_request(ble_pkg::OP_PUSH_FRONT, 0, 32'h8000_0000);
      queue_request(ble_pkg::OP_SORTED, 0, 32'h0);
      queue_request(ble_pkg::OP_SORTED, 0, '1);
      queue_request(ble_pkg::OP_SORTED, 0, 32'h7fff_ffff);
      queue_request(ble_pkg::OP_INSERT, 5, 32'h5);
      queue_request(ble_pkg::OP_INSERT, 31, 32'h9);
      queue_request(ble_pkg::OP_INSERT, 7, 32'h9);
      queue_request(ble_pkg::OP_FIND, 0, '1);
      queue_request(ble_pkg::OP_FIND, 0, 32'h3039);
      queue_request(ble_pkg::OP_REMOVE, 0, 32'h3039);
      queue_request(ble_pkg::OP_REMOVE, 0, 32'h7fff_ffff);
      queue_request(ble_pkg::OP_READ, 0, 0);
      queue_request(ble_pkg::OP_READ, 16, 0);
      queue_request(ble_pkg::OP_WRITE, 1, '1);
      queue_request(ble_pkg::OP_POP, 1, 0);
      queue_request(ble_pkg::OP_POP_BACK, 0, 0);
      queue_request(ble_pkg::OP_POP_FIRST, 0, 0);
      queue_request(ble_pkg::OP_CLEAR, 0, 0);
      wait_drained();

      // Random phases; the list is not cleared between them, so lowering the
      // capacity can leave it holding more entries than the new limit.
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         write_capacity(cap_plan[ph]);
         gaps_on = (ph != QUIET_PHASE);
         for (int n = 0; n < PHASE_ITEMS; n++)
            req_backlog.insert(req_backlog.size(), random_request(ph % 2 == 0));
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      while (awaited_rsp.size() != 0) begin
         flag_mismatch("missing result, entry_count", 0, awaited_rsp[0].entry_count);
         awaited_rsp.delete(0);
      end

      $display("Checked %0d results from %0d requests across %0d capacity writes.",
               checked, sent, cap_writes);
      $display("Status mix: ok %0d, full %0d, empty %0d, bad position %0d; %0d mismatches.",
               st_seen[ble_pkg::STAT_OK], st_seen[ble_pkg::STAT_FULL],
               st_seen[ble_pkg::STAT_EMPTY], st_seen[ble_pkg::STAT_BADPOS], mismatches);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
